// ===== sv/sep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep_pkg
// Types, constants and suite decoding shared by the security element parser.
// ----------------------------------------------------------------------------
package sep_pkg;

   localparam logic [8:0] POS_MAX  = 9'd511;
   localparam logic [6:0] SEEN_MAX = 7'd127;
   localparam logic [7:0] RSN_ID   = 8'd48;
   localparam logic [7:0] WPA_ID   = 8'd221;
   localparam logic [23:0] RSN_OUI = 24'h000FAC;
   localparam logic [23:0] WPA_OUI = 24'h0050F2;
   localparam logic [7:0] WPA_TAG [4] = '{8'h00, 8'h50, 8'hF2, 8'h01};

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_ID_LEN  = 3'd1;
   localparam logic [2:0] ST_SHORT_HDR   = 3'd2;
   localparam logic [2:0] ST_BAD_VERSION = 3'd3;
   localparam logic [2:0] ST_SHORT_GROUP = 3'd4;
   localparam logic [2:0] ST_SHORT_COUNT = 3'd5;
   localparam logic [2:0] ST_BAD_COUNT   = 3'd6;

   localparam logic [7:0] SUITE_NONE   = 8'd0;
   localparam logic [7:0] SUITE_WEP40  = 8'd1;
   localparam logic [7:0] SUITE_TKIP   = 8'd2;
   localparam logic [7:0] SUITE_CCMP   = 8'd4;
   localparam logic [7:0] SUITE_WEP104 = 8'd5;

   localparam logic [4:0] CIPH_NONE   = 5'b00001;
   localparam logic [4:0] CIPH_WEP40  = 5'b00010;
   localparam logic [4:0] CIPH_WEP104 = 5'b00100;
   localparam logic [4:0] CIPH_TKIP   = 5'b01000;
   localparam logic [4:0] CIPH_CCMP   = 5'b10000;

   localparam logic CSR_MODE_SEL = 1'b0;

   typedef struct packed {
      logic [7:0] elem_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] group_cipher;
      logic [4:0] pairwise_mask;
   } rsp_word_type;

   function automatic logic [4:0] suite_decode(input logic [31:0] word, input logic mode);
      logic [4:0] bits;
      bits = 5'd0;
      if (word[31:8] == (mode ? WPA_OUI : RSN_OUI)) begin
         unique case (word[7:0])
            SUITE_NONE:   bits = CIPH_NONE;
            SUITE_WEP40:  bits = CIPH_WEP40;
            SUITE_WEP104: bits = CIPH_WEP104;
            SUITE_TKIP:   bits = CIPH_TKIP;
            SUITE_CCMP:   bits = CIPH_CCMP;
            default:      bits = 5'd0;
         endcase
      end
      return bits;
   endfunction

endpackage

// ===== sv/sep_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep_csr
// APB-style register port holding the RSN/WPA mode bit.
// ----------------------------------------------------------------------------
module sep_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        wpa_mode
);
   import sep_pkg::*;

   logic mode_ff;
   logic mode_in;
   logic wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == CSR_MODE_SEL);

   always_comb begin
      mode_in = mode_ff;
      if (wr_hit) begin
         mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // low address bits select bytes within the word and are not decoded
   assign prdata   = (paddr[2] == CSR_MODE_SEL) ? {31'd0, mode_ff} : 32'd0;
   assign wpa_mode = mode_ff;

endmodule

// ===== sv/sep_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep_parse_core
// Per-byte field tracking and end-of-element status evaluation.
// ----------------------------------------------------------------------------
module sep_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  sep_pkg::req_word_type req_word,
   input  logic                  wpa_mode,
   output logic                  res_valid,
   output sep_pkg::rsp_word_type res_word
);
   import sep_pkg::*;

   logic [8:0]  pos_ff, pos_upd, pos_in;
   logic [7:0]  id_ff, id_upd, id_in;
   logic [7:0]  len_ff, len_upd, len_in;
   logic        oui_ff, oui_upd, oui_in;
   logic [15:0] ver_ff, ver_upd, ver_in;
   logic [4:0]  group_ff, group_upd, group_in;
   logic [15:0] count_ff, count_upd, count_in;
   logic [31:0] shift_ff, shift_upd, shift_in;
   logic [6:0]  seen_ff, seen_upd, seen_in;
   logic [4:0]  pair_ff, pair_upd, pair_in;

   logic [7:0]  v;
   logic [8:0]  body_idx;
   logic [8:0]  hdr;
   logic [8:0]  rel;
   logic [8:0]  left;
   logic [8:0]  tail;
   logic        bad_hdr;
   logic [2:0]  st;
   logic        emit;

   assign v   = req_word.elem_byte;
   assign hdr = wpa_mode ? 9'd4 : 9'd0;

   // field update for one byte
   always_comb begin
      pos_upd   = pos_ff;
      id_upd    = id_ff;
      len_upd   = len_ff;
      oui_upd   = oui_ff;
      ver_upd   = ver_ff;
      group_upd = group_ff;
      count_upd = count_ff;
      shift_upd = shift_ff;
      seen_upd  = seen_ff;
      pair_upd  = pair_ff;
      body_idx  = pos_ff - 9'd2;
      rel       = body_idx - hdr;
      if (pos_ff != POS_MAX) begin
         pos_upd = pos_ff + 9'd1;
         priority if (pos_ff == 9'd0) begin
            id_upd = v;
         end else if (pos_ff == 9'd1) begin
            len_upd = v;
         end else if (body_idx < hdr) begin
            if (body_idx == 9'd0) begin
               oui_upd = (v == WPA_TAG[0]);
            end else if (v != WPA_TAG[body_idx[1:0]]) begin
               oui_upd = 1'b0;
            end
         end else begin
            shift_upd = {shift_ff[23:0], v};
            priority if (rel == 9'd0) begin
               ver_upd = {8'd0, v};
            end else if (rel == 9'd1) begin
               ver_upd = ver_ff | {v, 8'd0};
            end else if (rel == 9'd5) begin
               group_upd = suite_decode(shift_upd, wpa_mode);
            end else if (rel == 9'd6) begin
               count_upd = {8'd0, v};
            end else if (rel == 9'd7) begin
               count_upd = count_ff | {v, 8'd0};
            end else if (rel >= 9'd8 && rel[1:0] == 2'd3) begin
               if ({9'd0, seen_ff} < count_ff) begin
                  pair_upd = pair_ff | suite_decode(shift_upd, wpa_mode);
               end
               if (seen_ff != SEEN_MAX) begin
                  seen_upd = seen_ff + 7'd1;
               end
            end else begin
               ver_upd = ver_ff;
            end
         end
      end
   end

   // end-of-element evaluation
   always_comb begin
      left    = (pos_upd >= 9'd2) ? (pos_upd - 9'd2) : 9'd0;
      tail    = left - (hdr + 9'd8);
      bad_hdr = (pos_upd < 9'd2) ||
                (id_upd != (wpa_mode ? WPA_ID : RSN_ID)) ||
                ({1'b0, pos_upd} < (10'd2 + {2'd0, len_upd}));
      priority if (bad_hdr) begin
         st = ST_BAD_ID_LEN;
      end else if (wpa_mode && left < 9'd4) begin
         st = ST_SHORT_HDR;
      end else if (wpa_mode && !oui_upd) begin
         st = ST_BAD_VERSION;
      end else if (left < hdr + 9'd2) begin
         st = ST_SHORT_HDR;
      end else if (ver_upd != 16'd1) begin
         st = ST_BAD_VERSION;
      end else if (left == hdr + 9'd2) begin
         st = ST_OK;
      end else if (left < hdr + 9'd6) begin
         st = ST_SHORT_GROUP;
      end else if (left == hdr + 9'd6) begin
         st = ST_OK;
      end else if (left < hdr + 9'd8) begin
         st = ST_SHORT_COUNT;
      end else if (count_upd == 16'd0 || {9'd0, tail} < {count_upd, 2'b00}) begin
         st = ST_BAD_COUNT;
      end else begin
         st = ST_OK;
      end
      // ciphers only on a full parse
      emit = (st == ST_OK) && !bad_hdr && (left >= hdr + 9'd8);
      res_word.status        = st;
      res_word.group_cipher  = emit ? group_upd : 5'd0;
      res_word.pairwise_mask = emit ? pair_upd : 5'd0;
   end

   assign res_valid = take && req_word.last_byte;

   // last byte returns the parser to its reset state
   always_comb begin
      pos_in   = pos_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      oui_in   = oui_ff;
      ver_in   = ver_ff;
      group_in = group_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      seen_in  = seen_ff;
      pair_in  = pair_ff;
      if (take) begin
         if (req_word.last_byte) begin
            pos_in   = 9'd0;
            id_in    = 8'd0;
            len_in   = 8'd0;
            oui_in   = 1'b0;
            ver_in   = 16'd0;
            group_in = 5'd0;
            count_in = 16'd0;
            shift_in = 32'd0;
            seen_in  = 7'd0;
            pair_in  = 5'd0;
         end else begin
            pos_in   = pos_upd;
            id_in    = id_upd;
            len_in   = len_upd;
            oui_in   = oui_upd;
            ver_in   = ver_upd;
            group_in = group_upd;
            count_in = count_upd;
            shift_in = shift_upd;
            seen_in  = seen_upd;
            pair_in  = pair_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 9'd0;
         id_ff    <= 8'd0;
         len_ff   <= 8'd0;
         oui_ff   <= 1'b0;
         ver_ff   <= 16'd0;
         group_ff <= 5'd0;
         count_ff <= 16'd0;
         shift_ff <= 32'd0;
         seen_ff  <= 7'd0;
         pair_ff  <= 5'd0;
      end else begin
         pos_ff   <= pos_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         oui_ff   <= oui_in;
         ver_ff   <= ver_in;
         group_ff <= group_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         seen_ff  <= seen_in;
         pair_ff  <= pair_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (take && req_word.last_byte) |=> (pos_ff == 9'd0 && pair_ff == 5'd0))
      else $error("parser state not cleared after last word");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      (take && !req_word.last_byte && pos_ff == POS_MAX) |=> (pos_ff == POS_MAX))
      else $error("byte position wrapped");

   a_err_no_cipher: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_word.status != ST_OK) |->
         (res_word.group_cipher == 5'd0 && res_word.pairwise_mask == 5'd0))
      else $error("cipher bits on error status");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      (seen_ff != 7'd0) |-> (pos_ff >= 9'd13))
      else $error("suite seen before any suite could complete");

endmodule

// ===== sv/sep_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep_out_skid
// Result register with a skid stage so the parser keeps taking words.
// ----------------------------------------------------------------------------
module sep_out_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sep_pkg::rsp_word_type in_word,
   output logic                  in_ready,
   output logic                  out_valid,
   output sep_pkg::rsp_word_type out_word,
   input  logic                  out_ready
);
   import sep_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         out_free;

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_word_in   = skid_valid_ff ? skid_word_ff : in_word;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word ahead of the output register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_valid)
      else $error("word arrived while skid full");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready && in_valid) |=> skid_valid_ff)
      else $error("stalled word not captured in skid");

   a_drain_skid: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && out_word_ff == $past(skid_word_ff)))
      else $error("skid word not moved to output");

endmodule

// ===== sv/security_element_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// security_element_parser_top
// RSN / WPA security information element parser, one element byte per word.
// ----------------------------------------------------------------------------
//  channel  direction  ports                          word
//  req      in         req_valid/req_ready/req_data   elem_byte, last_byte
//  rsp      out        rsp_valid/rsp_ready/rsp_data   status, group_cipher, pairwise_mask
//  csr      in/out     psel/penable/pwrite/paddr/...  wpa_mode at address 0
//
//  One req word per cycle while req_ready is high; the result of an element
//  is registered in the output buffer and shows on rsp from there.
//  The field update in the parse core handles each byte combinationally.
//  A two-entry output buffer (result register plus skid) sits before rsp;
//  req_ready drops only while both entries are full.
//  Synchronous reset clears the parser state, the mode bit and the buffer.
// ----------------------------------------------------------------------------
module security_element_parser_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sep_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sep_pkg::rsp_word_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import sep_pkg::*;

   logic         wpa_mode;
   logic         take;
   logic         res_valid;
   rsp_word_type res_word;
   logic         buf_ready;

   assign req_ready = buf_ready;
   assign take      = req_valid && buf_ready;

   sep_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .wpa_mode (wpa_mode)
   );

   sep_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_word  (req_data),
      .wpa_mode  (wpa_mode),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   sep_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_word   (res_word),
      .in_ready  (buf_ready),
      .out_valid (rsp_valid),
      .out_word  (rsp_data),
      .out_ready (rsp_ready)
   );

endmodule

// ===== dv/tb_security_element_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_security_element_parser_top
// Self-checking bench for the RSN / WPA security element parser. A short
// table of hand-built elements runs first. Randomized phases follow, each
// starting with a mode write; they mix well-formed elements with truncated
// ones, corrupted ones and noise. Every accepted byte goes through a local
// parse model, and each result word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_security_element_parser_top;
   import sep_pkg::*;

   localparam int         STALL_LIMIT = 2000;
   localparam int         SETTLE      = 4;
   localparam int         NUM_PHASES  = 8;
   localparam int         PHASE_WORDS = 34;
   localparam logic [2:0] MODE_ADDR   = {CSR_MODE_SEL, 2'b00};
   localparam logic [2:0] SPARE_ADDR  = 3'd4;

   localparam int SHAPE_FULL  = 0;
   localparam int SHAPE_CUT   = 1;
   localparam int SHAPE_NOISE = 2;

   typedef struct packed {
      logic [7:0]   word_byte;
      logic         fin;
      logic         typed;
      rsp_word_type want;
   } dir_row_type;

   localparam rsp_word_type NO_WORD = '0;

   localparam dir_row_type DIR_TAB [24] = '{
      '{RSN_ID, 1'b1, 1'b1, '{ST_BAD_ID_LEN, 5'd0, 5'd0}},
      '{8'hFF, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b1, 1'b1, '{ST_BAD_ID_LEN, 5'd0, 5'd0}},
      '{RSN_ID, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h01, 1'b1, 1'b1, '{ST_SHORT_HDR, 5'd0, 5'd0}},
      '{RSN_ID, 1'b0, 1'b0, NO_WORD},
      '{8'h02, 1'b0, 1'b0, NO_WORD},
      '{8'h01, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b1, 1'b1, '{ST_OK, 5'd0, 5'd0}},
      '{RSN_ID, 1'b0, 1'b0, NO_WORD},
      '{8'd12, 1'b0, 1'b0, NO_WORD},
      '{8'h01, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{RSN_OUI[23:16], 1'b0, 1'b0, NO_WORD},
      '{RSN_OUI[15:8], 1'b0, 1'b0, NO_WORD},
      '{RSN_OUI[7:0], 1'b0, 1'b0, NO_WORD},
      '{SUITE_TKIP, 1'b0, 1'b0, NO_WORD},
      '{8'h01, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{RSN_OUI[23:16], 1'b0, 1'b0, NO_WORD},
      '{RSN_OUI[15:8], 1'b0, 1'b0, NO_WORD},
      '{RSN_OUI[7:0], 1'b0, 1'b0, NO_WORD},
      '{SUITE_CCMP, 1'b1, 1'b1, '{ST_OK, CIPH_TKIP, CIPH_CCMP}}
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b1;
   rsp_word_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   // parse model state
   logic         cfg_wpa;
   logic [8:0]   el_pos;
   logic [7:0]   el_id;
   logic [7:0]   el_len;
   logic         el_oui;
   logic [15:0]  el_ver;
   logic [4:0]   el_group;
   logic [15:0]  el_count;
   logic [31:0]  el_window;
   logic [6:0]   el_done_suites;
   logic [4:0]   el_pairs;

   rsp_word_type pending [$];
   req_word_type byte_q [$];

   logic         calm = 1'b0;
   int           stall_left = 0;
   int           idle_cycles = 0;
   int           err_count = 0;
   int           words_sent = 0;
   int           results_seen = 0;
   int           phase_words = 0;
   logic [7:0]   status_seen = '0;

   security_element_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic log_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      err_count++;
      if (err_count <= 10)
         $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   function automatic logic [4:0] cipher_of(input logic [31:0] suite, input logic wpa);
      logic [23:0] oui;
      oui = wpa ? WPA_OUI : RSN_OUI;
      if (suite[31:8] != oui)      return 5'd0;
      if (suite[7:0] == SUITE_NONE)   return CIPH_NONE;
      if (suite[7:0] == SUITE_WEP40)  return CIPH_WEP40;
      if (suite[7:0] == SUITE_WEP104) return CIPH_WEP104;
      if (suite[7:0] == SUITE_TKIP)   return CIPH_TKIP;
      if (suite[7:0] == SUITE_CCMP)   return CIPH_CCMP;
      return 5'd0;
   endfunction

   task automatic clear_parse();
      el_pos = '0;
      el_id = '0;
      el_len = '0;
      el_oui = 1'b0;
      el_ver = '0;
      el_group = '0;
      el_count = '0;
      el_window = '0;
      el_done_suites = '0;
      el_pairs = '0;
   endtask

   task automatic parse_word(input req_word_type w, output logic got,
                             output rsp_word_type res);
      int         b, hdr, r_off, plen, left;
      logic [2:0] st;
      logic [4:0] g, pm;
      got = 1'b0;
      res = '0;
      hdr = cfg_wpa ? 4 : 0;
      if (el_pos < POS_MAX) begin
         if (el_pos == 0) begin
            el_id = w.elem_byte;
         end else if (el_pos == 1) begin
            el_len = w.elem_byte;
         end else begin
            b = int'(el_pos) - 2;
            if (b < hdr) begin
               if (b == 0)
                  el_oui = (w.elem_byte == WPA_TAG[0]);
               else if (w.elem_byte != WPA_TAG[b])
                  el_oui = 1'b0;
            end else begin
               r_off = b - hdr;
               el_window = {el_window[23:0], w.elem_byte};
               if (r_off == 0) begin
                  el_ver = {8'd0, w.elem_byte};
               end else if (r_off == 1) begin
                  el_ver = el_ver | {w.elem_byte, 8'd0};
               end else if (r_off == 5) begin
                  el_group = cipher_of(el_window, cfg_wpa);
               end else if (r_off == 6) begin
                  el_count = {8'd0, w.elem_byte};
               end else if (r_off == 7) begin
                  el_count = el_count | {w.elem_byte, 8'd0};
               end else if (r_off >= 8 && ((r_off - 8) % 4) == 3) begin
                  if ({9'd0, el_done_suites} < el_count)
                     el_pairs = el_pairs | cipher_of(el_window, cfg_wpa);
                  if (el_done_suites < SEEN_MAX)
                     el_done_suites = el_done_suites + 7'd1;
               end
            end
         end
         el_pos = el_pos + 9'd1;
      end
      if (!w.last_byte)
         return;

      plen = int'(el_pos);
      left = (plen >= 2) ? plen - 2 : 0;
      g = '0;
      pm = '0;
      if (plen < 2 || el_id != (cfg_wpa ? WPA_ID : RSN_ID) || plen < 2 + int'(el_len))
         st = ST_BAD_ID_LEN;
      else if (cfg_wpa && left < 4)
         st = ST_SHORT_HDR;
      else if (cfg_wpa && !el_oui)
         st = ST_BAD_VERSION;
      else if (left < hdr + 2)
         st = ST_SHORT_HDR;
      else if (el_ver != 16'd1)
         st = ST_BAD_VERSION;
      else if (left == hdr + 2)
         st = ST_OK;
      else if (left < hdr + 6)
         st = ST_SHORT_GROUP;
      else if (left == hdr + 6)
         st = ST_OK;
      else if (left < hdr + 8)
         st = ST_SHORT_COUNT;
      else if (el_count == 0 || left - (hdr + 8) < int'(el_count) * 4)
         st = ST_BAD_COUNT;
      else begin
         st = ST_OK;
         g = el_group;
         pm = el_pairs;
      end
      res.status = st;
      res.group_cipher = g;
      res.pairwise_mask = pm;
      got = 1'b1;
      clear_parse();
   endtask

   function automatic logic [31:0] rand_suite(input logic [23:0] oui);
      logic [7:0] kind;
      case ($urandom_range(0, 7))
         0:       kind = SUITE_NONE;
         1:       kind = SUITE_WEP40;
         2:       kind = SUITE_TKIP;
         3:       kind = SUITE_CCMP;
         4:       kind = SUITE_WEP104;
         5:       kind = 8'($urandom);
         default: kind = $urandom_range(0, 1) ? SUITE_CCMP : SUITE_TKIP;
      endcase
      if ($urandom_range(0, 11) == 0)
         oui = 24'($urandom);
      return {oui, kind};
   endfunction

   task automatic build_element(input logic wpa, input int shape);
      logic [7:0]   body [$];
      logic [23:0]  oui;
      logic [31:0]  sw;
      logic [15:0]  ver, cnt;
      logic [7:0]   dlen;
      req_word_type w;
      int           n_suites, tot, cut, hdr;
      oui = wpa ? WPA_OUI : RSN_OUI;
      hdr = wpa ? 4 : 0;
      if (shape == SHAPE_NOISE) begin
         tot = $urandom_range(1, 24);
         for (int i = 0; i < tot; i++) begin
            w.elem_byte = 8'($urandom);
            w.last_byte = (i == tot - 1);
            byte_q.push_back(w);
         end
         return;
      end
      if (wpa) begin
         for (int i = 0; i < 4; i++)
            body.push_back(WPA_TAG[i]);
         if ($urandom_range(0, 9) == 0)
            body[$urandom_range(0, 3)] = 8'($urandom);
      end
      ver = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd1;
      body.push_back(ver[7:0]);
      body.push_back(ver[15:8]);
      sw = rand_suite(oui);
      for (int i = 3; i >= 0; i--)
         body.push_back(sw[8*i +: 8]);
      case ($urandom_range(0, 9))
         0:       cnt = 16'd0;
         1:       cnt = 16'($urandom);
         default: cnt = 16'($urandom_range(1, 4));
      endcase
      body.push_back(cnt[7:0]);
      body.push_back(cnt[15:8]);
      if (cnt > 4)
         n_suites = $urandom_range(0, 4);
      else begin
         case ($urandom_range(0, 7))
            0:       n_suites = int'(cnt) + $urandom_range(1, 2);
            1:       n_suites = (cnt > 0) ? int'(cnt) - 1 : 0;
            default: n_suites = int'(cnt);
         endcase
      end
      for (int s = 0; s < n_suites; s++) begin
         sw = rand_suite(oui);
         for (int i = 3; i >= 0; i--)
            body.push_back(sw[8*i +: 8]);
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      if (shape == SHAPE_CUT) begin
         case ($urandom_range(0, 3))
            0:       cut = hdr + 2;
            1:       cut = hdr + 6;
            2:       cut = hdr + 8;
            default: cut = $urandom_range(0, body.size() - 1);
         endcase
         while (body.size() > cut)
            void'(body.pop_back());
      end
      dlen = (body.size() > 255) ? 8'd255 : 8'(body.size());
      if ($urandom_range(0, 7) == 0)
         dlen = 8'($urandom);
      w.elem_byte = ($urandom_range(0, 11) == 0) ? 8'($urandom) : (wpa ? WPA_ID : RSN_ID);
      w.last_byte = 1'b0;
      byte_q.push_back(w);
      w.elem_byte = dlen;
      w.last_byte = (body.size() == 0);
      byte_q.push_back(w);
      foreach (body[i]) begin
         w.elem_byte = body[i];
         w.last_byte = (i == body.size() - 1);
         byte_q.push_back(w);
      end
   endtask

   task automatic send_one(input req_word_type w, input logic typed,
                           input rsp_word_type typed_val);
      int           gap;
      logic         got;
      rsp_word_type pred;
      gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      parse_word(w, got, pred);
      if (got)
         pending.push_back(typed ? typed_val : pred);
   endtask

   task automatic send_front();
      req_word_type w;
      w = byte_q.pop_front();
      send_one(w, 1'b0, NO_WORD);
      phase_words++;
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr && addr == MODE_ADDR)
         cfg_wpa = data[0];
      if (!wr && prdata !== {31'd0, cfg_wpa})
         log_mismatch("mode readback", {31'd0, cfg_wpa}, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         status_seen[rsp_data.status] = 1'b1;
         if (pending.size() == 0) begin
            log_mismatch("result with nothing pending", 32'd0, 32'(rsp_data));
         end else begin
            want = pending.pop_front();
            if (rsp_data.status !== want.status)
               log_mismatch("status", 32'(want.status), 32'(rsp_data.status));
            if (rsp_data.group_cipher !== want.group_cipher)
               log_mismatch("group_cipher", 32'(want.group_cipher),
                            32'(rsp_data.group_cipher));
            if (rsp_data.pairwise_mask !== want.pairwise_mask)
               log_mismatch("pairwise_mask", 32'(want.pairwise_mask),
                            32'(rsp_data.pairwise_mask));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d words pending",
                     STALL_LIMIT, pending.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_word_type w;
      logic         mode_now;
      logic [31:0]  wdata;
      int           cut;
      cfg_wpa = 1'b0;
      clear_parse();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_TAB[i]) begin
         w.elem_byte = DIR_TAB[i].word_byte;
         w.last_byte = DIR_TAB[i].fin;
         send_one(w, DIR_TAB[i].typed, DIR_TAB[i].want);
      end
      req_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         if (ph == NUM_PHASES - 1)
            calm = 1'b1;
         mode_now = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
         wdata = $urandom;
         wdata[0] = mode_now;
         csr_access(1'b1, MODE_ADDR, wdata);
         csr_access(1'b0, MODE_ADDR, '0);
         if (ph == 2) begin
            csr_access(1'b1, SPARE_ADDR, $urandom);
            csr_access(1'b0, MODE_ADDR, '0);
         end
         phase_words = 0;
         // leftover of an element split across a mode change goes first
         while (byte_q.size() != 0)
            send_front();
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            case ($urandom_range(0, 9))
               6, 7:    build_element(mode_now, SHAPE_CUT);
               8, 9:    build_element(mode_now, SHAPE_NOISE);
               default: build_element(mode_now, SHAPE_FULL);
            endcase
            while (byte_q.size() != 0)
               send_front();
         end
         if (ph % 2 == 1 && ph < NUM_PHASES - 1) begin
            build_element(mode_now, SHAPE_FULL);
            cut = $urandom_range(1, byte_q.size() - 1);
            repeat (cut) send_front();
         end
         req_idle();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered: %0d words, %0d results, RSN and WPA modes with mid-element switches",
               words_sent, results_seen);
      $display("covered: status codes seen %b over full, truncated and noise elements",
               status_seen[6:0]);
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== security_element_parser_top.f =====
sv/sep_pkg.sv
sv/sep_csr.sv
sv/sep_parse_core.sv
sv/sep_out_skid.sv
sv/security_element_parser_top.sv
dv/tb_security_element_parser_top.sv
